### rtl/nfcs_pkg.sv
// ----------------------------------------------------------------------------
// nfcs_pkg: shared types and constants for the NOR flash command sequencer
// Payload structs, command codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package nfcs_pkg;

  // Geometry
  localparam int unsigned SECTORS       = 135;
  localparam int unsigned SMALL_SECTORS = 8;
  localparam int unsigned SECT_W        = 8;
  localparam int unsigned ADDR_W        = 23;
  localparam int unsigned WADDR_W       = 22;
  localparam int unsigned DATA_W        = 16;
  localparam int unsigned TICK_W        = 20;
  localparam int unsigned STEP_W        = 3;
  localparam int unsigned CFG_W         = 1;
  localparam int unsigned SMALL_SHIFT   = 13;  // 8 KiB sectors
  localparam int unsigned LARGE_SHIFT   = 16;  // 64 KiB sectors

  localparam logic [ADDR_W-1:0] SMALL_AREA  = ADDR_W'(SMALL_SECTORS * (8 * 1024));
  localparam logic [SECT_W-1:0] LAST_SECTOR = SECT_W'(SECTORS - 1);
  localparam logic [SECT_W-1:0] SMALL_COUNT = SECT_W'(SMALL_SECTORS);

  // Unlock command addresses and data
  localparam logic [ADDR_W-1:0] CMD_ADDR_A   = 23'h000AAA;
  localparam logic [ADDR_W-1:0] CMD_ADDR_B   = 23'h000555;
  localparam logic [DATA_W-1:0] CMD_UNLOCK_1 = 16'h00AA;
  localparam logic [DATA_W-1:0] CMD_UNLOCK_2 = 16'h0055;
  localparam logic [DATA_W-1:0] CMD_ERASE    = 16'h0080;
  localparam logic [DATA_W-1:0] CMD_SECTOR   = 16'h0030;
  localparam logic [DATA_W-1:0] CMD_PROGRAM  = 16'h00A0;
  localparam logic [7:0]        ERASED_BYTE  = 8'hFF;

  localparam logic [TICK_W-1:0] TICK_MAX          = '1;
  localparam logic [TICK_W-1:0] ERASE_TIMEOUT_RST = 20'd120000;
  localparam logic [TICK_W-1:0] WRITE_TIMEOUT_RST = 20'd500;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] CFG_ERASE_TIMEOUT = 1'b0;
  localparam logic [CFG_W-1:0] CFG_WRITE_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    OP_ERASE       = 3'd0,
    OP_PROGRAM     = 3'd1,
    OP_READ_DATA   = 3'd2,
    OP_TICK        = 3'd3,
    OP_SET_PROTECT = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TIMEOUT    = 2'd1,
    ST_NOT_ERASED = 2'd2,
    ST_BAD_RANGE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_ERASE_POLL = 2'd1,
    MODE_PROG_CHECK = 2'd2,
    MODE_PROG_POLL  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    SEQ_ERASE       = 3'd0,
    SEQ_PROGRAM     = 3'd1,
    SEQ_READ_WORD   = 3'd2,
    SEQ_READ_SECTOR = 3'd3,
    SEQ_DONE        = 3'd4
  } seq_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [SECT_W-1:0]  first_sector;
    logic [SECT_W-1:0]  last_sector;
    logic [WADDR_W-1:0] word_address;
    logic [DATA_W-1:0]  write_data;
    logic               last_word;
    logic [DATA_W-1:0]  read_data;
    logic               protect_flag;
  } nfcs_in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] bus_data;
    logic              bus_word;
    logic [1:0]        status;
    logic              run_last;
  } nfcs_out_t;

  // Controller -> datapath
  typedef struct packed {
    logic              capture;
    logic              start_range;
    logic              sector_inc;
    logic              mode_we;
    mode_e             mode;
    logic              set_wait;
    logic              clr_wait;
    logic              clr_ticks;
    logic              inc_ticks;
    logic              load_pending;
    logic              set_protect;
    logic              emit;
    seq_e              seq;
    logic [STEP_W-1:0] step;
    status_e           status;
    logic              last;
  } nfcs_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [2:0] opcode;
    mode_e      mode;
    logic       awaiting;
    logic       range_bad;
    logic       erase_poll_ok;
    logic       prog_check_ok;
    logic       prog_poll_ok;
    logic       pending_last;
    logic       scan_in_range;
    logic       scan_unprotected;
    logic       timed_out;
    logic       out_free;
    logic       init_busy;
  } nfcs_stat_t;

  // Index of the final result of each bus sequence
  function automatic logic [STEP_W-1:0] seq_last_step(seq_e seq);
    logic [STEP_W-1:0] r;
    unique case (seq)
      SEQ_ERASE:   r = STEP_W'(6);
      SEQ_PROGRAM: r = STEP_W'(4);
      default:     r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/nfcs_ctrl.sv
// ----------------------------------------------------------------------------
// nfcs_ctrl: sequencer controller
// Decodes each request against the flash mode, walks the sector range and
// steps through the bus sequence one result at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nfcs_pkg::nfcs_stat_t stat_i,
  output nfcs_pkg::nfcs_cmd_t  cmd_o
);
  import nfcs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_TICK   = 5'b00100,
    S_SCAN   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  seq_e              seq_q, seq_d;
  status_e           status_q, status_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last_step;

  // held off while a request is in hand or the protect RAM is being filled after reset
  assign in_stall_o = (state_q != S_IDLE) || stat_i.init_busy;
  assign last_step  = (step_q == seq_last_step(seq_q));

  always_comb begin
    state_d  = state_q;
    seq_d    = seq_q;
    status_d = status_q;
    step_d   = step_q;

    cmd_o         = '0;
    cmd_o.mode    = MODE_IDLE;
    cmd_o.seq     = seq_q;
    cmd_o.step    = step_q;
    cmd_o.status  = status_q;
    cmd_o.last    = last_step;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !stat_i.init_busy) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_IDLE;
        step_d  = '0;
        case (stat_i.opcode)
          OP_ERASE: begin
            if (stat_i.mode == MODE_IDLE) begin
              if (stat_i.range_bad) begin
                cmd_o.mode_we  = 1'b1;
                cmd_o.clr_wait = 1'b1;
                seq_d          = SEQ_DONE;
                status_d       = ST_BAD_RANGE;
                state_d        = S_EMIT;
              end else begin
                cmd_o.start_range = 1'b1;
                state_d           = S_SCAN;
              end
            end
          end

          OP_PROGRAM: begin
            if (stat_i.mode == MODE_IDLE) begin
              cmd_o.load_pending = 1'b1;
              cmd_o.mode_we      = 1'b1;
              cmd_o.mode         = MODE_PROG_CHECK;
              cmd_o.clr_wait     = 1'b1;
              seq_d              = SEQ_READ_WORD;
              status_d           = ST_OK;
              state_d            = S_EMIT;
            end
          end

          OP_READ_DATA: begin
            if (stat_i.mode != MODE_IDLE && !stat_i.awaiting) begin
              case (stat_i.mode)
                MODE_ERASE_POLL: begin
                  if (stat_i.erase_poll_ok) begin
                    cmd_o.sector_inc = 1'b1;
                    state_d          = S_SCAN;
                  end else begin
                    cmd_o.set_wait = 1'b1;
                  end
                end
                MODE_PROG_CHECK: begin
                  if (!stat_i.prog_check_ok) begin
                    cmd_o.mode_we  = 1'b1;
                    cmd_o.clr_wait = 1'b1;
                    seq_d          = SEQ_DONE;
                    status_d       = ST_NOT_ERASED;
                  end else begin
                    cmd_o.mode_we   = 1'b1;
                    cmd_o.mode      = MODE_PROG_POLL;
                    cmd_o.clr_ticks = 1'b1;
                    seq_d           = SEQ_PROGRAM;
                    status_d        = ST_OK;
                  end
                  state_d = S_EMIT;
                end
                default: begin
                  // programme poll
                  if (stat_i.prog_poll_ok) begin
                    cmd_o.mode_we = 1'b1;
                    if (stat_i.pending_last) begin
                      cmd_o.clr_wait = 1'b1;
                      seq_d          = SEQ_DONE;
                      status_d       = ST_OK;
                      state_d        = S_EMIT;
                    end
                  end else begin
                    cmd_o.set_wait = 1'b1;
                  end
                end
              endcase
            end
          end

          OP_TICK: begin
            if (stat_i.mode != MODE_IDLE && stat_i.awaiting) begin
              cmd_o.inc_ticks = 1'b1;
              state_d         = S_TICK;
            end
          end

          OP_SET_PROTECT: cmd_o.set_protect = 1'b1;

          default: ;
        endcase
      end

      S_TICK: begin
        step_d  = '0;
        state_d = S_EMIT;
        if (stat_i.timed_out) begin
          cmd_o.mode_we  = 1'b1;
          cmd_o.clr_wait = 1'b1;
          seq_d          = SEQ_DONE;
          status_d       = ST_TIMEOUT;
        end else begin
          cmd_o.clr_wait = 1'b1;
          seq_d    = (stat_i.mode == MODE_ERASE_POLL) ? SEQ_READ_SECTOR : SEQ_READ_WORD;
          status_d = ST_OK;
        end
      end

      S_SCAN: begin
        step_d = '0;
        if (stat_i.scan_in_range) begin
          if (stat_i.scan_unprotected) begin
            cmd_o.mode_we   = 1'b1;
            cmd_o.mode      = MODE_ERASE_POLL;
            cmd_o.clr_ticks = 1'b1;
            cmd_o.clr_wait  = 1'b1;
            seq_d           = SEQ_ERASE;
            status_d        = ST_OK;
            state_d         = S_EMIT;
          end else begin
            cmd_o.sector_inc = 1'b1;
          end
        end else begin
          cmd_o.mode_we  = 1'b1;
          cmd_o.clr_wait = 1'b1;
          seq_d          = SEQ_DONE;
          status_d       = ST_OK;
          state_d        = S_EMIT;
        end
      end

      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (last_step) begin
            state_d = S_IDLE;
          end else begin
            step_d = step_q + STEP_W'(1);
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      seq_q    <= SEQ_DONE;
      status_q <= ST_OK;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      seq_q    <= seq_d;
      status_q <= status_d;
      step_q   <= step_d;
    end
  end

endmodule

`default_nettype wire

### rtl/nfcs_dp.sv
// ----------------------------------------------------------------------------
// nfcs_dp: sequencer datapath
// Request register, flash mode state, protect map, tick counter, timeout
// registers and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcs_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nfcs_pkg::nfcs_in_t              in_data_i,
  input  logic                            cfg_we_i,
  input  logic [nfcs_pkg::CFG_W-1:0]      cfg_index_i,
  input  logic [nfcs_pkg::TICK_W-1:0]     cfg_wdata_i,
  input  nfcs_pkg::nfcs_cmd_t             cmd_i,
  output nfcs_pkg::nfcs_stat_t            stat_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output nfcs_pkg::nfcs_out_t             out_data_o
);
  import nfcs_pkg::*;

  nfcs_in_t           item_q;
  mode_e              mode_q;
  logic               awaiting_q;
  logic [SECT_W-1:0]  cur_q, cur_d;
  logic [SECT_W-1:0]  range_end_q;
  logic [WADDR_W-1:0] pend_addr_q;
  logic [DATA_W-1:0]  pend_data_q;
  logic               pend_last_q;
  logic [TICK_W-1:0]  ticks_q;
  logic [TICK_W-1:0]  erase_to_q;
  logic [TICK_W-1:0]  write_to_q;
  logic               protect_mem [SECTORS];
  logic               protect_rd_q;
  logic               init_q;
  logic [SECT_W-1:0]  init_idx_q;
  logic               out_valid_q;
  nfcs_out_t          out_q;

  logic [ADDR_W-1:0]  sector_addr;
  logic [ADDR_W-1:0]  word_addr;
  logic [TICK_W-1:0]  limit;
  logic               in_range;
  nfcs_out_t          rec;

  assign word_addr = {pend_addr_q, 1'b0};
  assign limit     = (mode_q == MODE_ERASE_POLL) ? erase_to_q : write_to_q;
  assign in_range  = (cur_q <= range_end_q) && (cur_q < SECT_W'(SECTORS));

  // Next sector; the protect RAM is read at this address so its entry for
  // cur_q is ready in the cycle that looks at it
  always_comb begin
    cur_d = cur_q;
    if (cmd_i.start_range) begin
      cur_d = item_q.first_sector;
    end else if (cmd_i.sector_inc) begin
      cur_d = cur_q + SECT_W'(1);
    end
  end

  always_comb begin
    if (cur_q < SMALL_COUNT) begin
      sector_addr = ADDR_W'(cur_q) << SMALL_SHIFT;
    end else begin
      sector_addr = SMALL_AREA + (ADDR_W'(cur_q - SMALL_COUNT) << LARGE_SHIFT);
    end
  end

  always_comb begin
    stat_o                  = '0;
    stat_o.opcode           = item_q.opcode;
    stat_o.mode             = mode_q;
    stat_o.awaiting         = awaiting_q;
    stat_o.range_bad        = item_q.first_sector > item_q.last_sector;
    stat_o.erase_poll_ok    = item_q.read_data[7:0] == ERASED_BYTE;
    stat_o.prog_check_ok    = (item_q.read_data & pend_data_q) == pend_data_q;
    stat_o.prog_poll_ok     = item_q.read_data == pend_data_q;
    stat_o.pending_last     = pend_last_q;
    stat_o.scan_in_range    = in_range;
    stat_o.scan_unprotected = in_range && !protect_rd_q;
    stat_o.timed_out        = ticks_q > limit;
    stat_o.out_free         = !out_valid_q || !out_stall_i;
    stat_o.init_busy        = init_q;
  end

  // Result record for the current step of the bus sequence
  always_comb begin
    rec          = '0;
    rec.kind     = KIND_WRITE;
    rec.run_last = cmd_i.last;
    case (cmd_i.seq)
      SEQ_ERASE: begin
        case (cmd_i.step)
          3'd0:    begin rec.bus_address = CMD_ADDR_A; rec.bus_data = CMD_UNLOCK_1; end
          3'd1:    begin rec.bus_address = CMD_ADDR_B; rec.bus_data = CMD_UNLOCK_2; end
          3'd2:    begin rec.bus_address = CMD_ADDR_A; rec.bus_data = CMD_ERASE;    end
          3'd3:    begin rec.bus_address = CMD_ADDR_A; rec.bus_data = CMD_UNLOCK_1; end
          3'd4:    begin rec.bus_address = CMD_ADDR_B; rec.bus_data = CMD_UNLOCK_2; end
          3'd5:    begin rec.bus_address = sector_addr; rec.bus_data = CMD_SECTOR;  end
          default: begin rec.kind = KIND_READ; rec.bus_address = sector_addr; end
        endcase
      end
      SEQ_PROGRAM: begin
        case (cmd_i.step)
          3'd0: begin rec.bus_address = CMD_ADDR_A; rec.bus_data = CMD_UNLOCK_1; end
          3'd1: begin rec.bus_address = CMD_ADDR_B; rec.bus_data = CMD_UNLOCK_2; end
          3'd2: begin rec.bus_address = CMD_ADDR_A; rec.bus_data = CMD_PROGRAM;  end
          3'd3: begin
            rec.bus_address = word_addr;
            rec.bus_data    = pend_data_q;
            rec.bus_word    = 1'b1;
          end
          default: begin
            rec.kind        = KIND_READ;
            rec.bus_address = word_addr;
            rec.bus_word    = 1'b1;
          end
        endcase
      end
      SEQ_READ_WORD: begin
        rec.kind        = KIND_READ;
        rec.bus_address = word_addr;
        rec.bus_word    = 1'b1;
      end
      SEQ_READ_SECTOR: begin
        rec.kind        = KIND_READ;
        rec.bus_address = sector_addr;
      end
      default: begin
        rec.kind   = KIND_DONE;
        rec.status = cmd_i.status;
      end
    endcase
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      awaiting_q  <= 1'b0;
      cur_q       <= '0;
      range_end_q <= '0;
      pend_addr_q <= '0;
      pend_data_q <= '0;
      pend_last_q <= 1'b0;
      ticks_q     <= '0;
    end else begin
      if (cmd_i.mode_we) begin
        mode_q <= cmd_i.mode;
      end
      if (cmd_i.set_wait) begin
        awaiting_q <= 1'b1;
      end else if (cmd_i.clr_wait) begin
        awaiting_q <= 1'b0;
      end
      cur_q <= cur_d;
      if (cmd_i.start_range) begin
        range_end_q <= (item_q.last_sector > LAST_SECTOR) ? LAST_SECTOR
                                                          : item_q.last_sector;
      end
      if (cmd_i.load_pending) begin
        pend_addr_q <= item_q.word_address;
        pend_data_q <= item_q.write_data;
        pend_last_q <= item_q.last_word;
      end
      if (cmd_i.clr_ticks) begin
        ticks_q <= '0;
      end else if (cmd_i.inc_ticks && ticks_q != TICK_MAX) begin
        ticks_q <= ticks_q + TICK_W'(1);
      end
    end
  end

  // Clearing pass after reset: one protect entry per cycle marked protected
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= 1'b1;
      init_idx_q <= '0;
    end else if (init_q) begin
      init_idx_q <= init_idx_q + SECT_W'(1);
      if (init_idx_q == LAST_SECTOR) begin
        init_q <= 1'b0;
      end
    end
  end

  // Protect map RAM, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (init_q) begin
      protect_mem[init_idx_q] <= 1'b1;
    end else if (cmd_i.set_protect && item_q.first_sector < SECT_W'(SECTORS)) begin
      protect_mem[item_q.first_sector] <= item_q.protect_flag;
    end
    if (cur_d < SECT_W'(SECTORS)) begin
      protect_rd_q <= protect_mem[cur_d];
    end
  end

  // Timeout registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_to_q <= ERASE_TIMEOUT_RST;
      write_to_q <= WRITE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ERASE_TIMEOUT: erase_to_q <= cfg_wdata_i;
        CFG_WRITE_TIMEOUT: write_to_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Result output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/nor_flash_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// nor_flash_command_sequencer_top: AMD command set NOR flash sequencer
// Turns erase, programme, read-data, tick and protect requests into flash
// bus cycles and completion results.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i) takes one request;
//    output channel (out_valid_o / out_stall_i / out_data_o) gives its
//    results in order, run_last marking the final one of each request.
//  - One request at a time: in_stall_o stays high from acceptance until the
//    last result, if any, is loaded into the output register.
//  - A request gives either no result or up to 7 results; a tick passes
//    through a timeout compare state first, and an erase through one scan
//    state per sector looked at, the sector it stops on or the end of the
//    range included.
//  - The result register lets the next request in while the final result
//    waits; a stalled receiver holds the sequencer on its next result.
//  - Reset: all sectors protected, flash mode idle, timeouts 120000 (erase)
//    and 500 (write) ticks. A clearing pass fills the protect RAM with ones,
//    with in_stall_o held high meanwhile.
//  - Timeout registers are written via cfg_we_i / cfg_index_i / cfg_wdata_i
//    while no request is in flight; the user keeps to this, the block does not.
// ----------------------------------------------------------------------------
`default_nettype none

module nor_flash_command_sequencer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  nfcs_pkg::nfcs_in_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output nfcs_pkg::nfcs_out_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [nfcs_pkg::CFG_W-1:0]  cfg_index_i,
  input  logic [nfcs_pkg::TICK_W-1:0] cfg_wdata_i
);
  import nfcs_pkg::*;

  nfcs_cmd_t  cmd;   // controller -> datapath
  nfcs_stat_t stat;  // datapath -> controller

  nfcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nfcs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A request is never followed by a second one in the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one still decoding");

  // Completion is always the final result of a request
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_DONE |-> out_data_o.run_last)
    else $error("done result without run_last");

  // Results are only loaded while a request is being worked on and the output register is free
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> in_stall_o && stat.out_free)
    else $error("result loaded outside a request or over a held result");

  // Bus cycles carry no status
  a_bus_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_DONE |-> out_data_o.status == ST_OK)
    else $error("status set on a bus cycle");

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for nor_flash_command_sequencer_top
// Plays the flash host: issues erase, programme, read-data, tick and protect
// requests, mostly as well-formed poll sequences, and checks every bus cycle
// and completion result against a cycle-free model kept in a scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import nfcs_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 200;   // covers a full 135 sector scan
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned PHASE_REQUESTS = 70;
  localparam logic [2:0]  OP_UNUSED      = 3'd5;  // first opcode with no meaning

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_pattern_e;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the bus cycles and completions of each request and
  // checks the results leaving the block in order.
  // --------------------------------------------------------------------------
  class flash_seq_scoreboard;
    bit                 protect_map [SECTORS];
    mode_e              mode;
    int unsigned        cur_sector;
    int unsigned        range_end;
    int unsigned        elapsed;
    logic [WADDR_W-1:0] pend_addr;
    logic [DATA_W-1:0]  pend_data;
    bit                 pend_last;
    bit                 awaiting;
    int unsigned        erase_limit;
    int unsigned        write_limit;
    nfcs_out_t          expected_q[$];
    nfcs_out_t          batch[$];
    int unsigned        mismatches;

    function new();
      foreach (protect_map[i]) protect_map[i] = 1'b1;
      mode        = MODE_IDLE;
      cur_sector  = 0;
      range_end   = 0;
      elapsed     = 0;
      pend_addr   = '0;
      pend_data   = '0;
      pend_last   = 1'b0;
      awaiting    = 1'b0;
      erase_limit = ERASE_TIMEOUT_RST;
      write_limit = WRITE_TIMEOUT_RST;
      mismatches  = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_timeout(logic [CFG_W-1:0] idx, logic [TICK_W-1:0] value);
      if (idx == CFG_ERASE_TIMEOUT) erase_limit = value;
      else write_limit = value;
    endfunction

    function void queue_result(kind_e k, logic [ADDR_W-1:0] addr,
                               logic [DATA_W-1:0] data, logic word, status_e st);
      nfcs_out_t r;
      r.kind        = k;
      r.bus_address = addr;
      r.bus_data    = data;
      r.bus_word    = word;
      r.status      = st;
      r.run_last    = 1'b0;
      batch.push_back(r);
    endfunction

    function void finish_op(status_e st);
      queue_result(KIND_DONE, '0, '0, 1'b0, st);
      mode     = MODE_IDLE;
      awaiting = 1'b0;
    endfunction

    function logic [ADDR_W-1:0] sector_base(int unsigned s);
      if (s < SMALL_SECTORS) return ADDR_W'(s << SMALL_SHIFT);
      return SMALL_AREA + ADDR_W'((s - SMALL_SECTORS) << LARGE_SHIFT);
    endfunction

    // walk from s to the range end, starting the erase of the first open sector
    function void erase_next(int unsigned s);
      logic [ADDR_W-1:0] base;
      while (s <= range_end && s < SECTORS) begin
        if (!protect_map[s]) begin
          base       = sector_base(s);
          cur_sector = s;
          queue_result(KIND_WRITE, CMD_ADDR_A, CMD_UNLOCK_1, 1'b0, ST_OK);
          queue_result(KIND_WRITE, CMD_ADDR_B, CMD_UNLOCK_2, 1'b0, ST_OK);
          queue_result(KIND_WRITE, CMD_ADDR_A, CMD_ERASE, 1'b0, ST_OK);
          queue_result(KIND_WRITE, CMD_ADDR_A, CMD_UNLOCK_1, 1'b0, ST_OK);
          queue_result(KIND_WRITE, CMD_ADDR_B, CMD_UNLOCK_2, 1'b0, ST_OK);
          queue_result(KIND_WRITE, base, CMD_SECTOR, 1'b0, ST_OK);
          queue_result(KIND_READ, base, '0, 1'b0, ST_OK);
          mode     = MODE_ERASE_POLL;
          elapsed  = 0;
          awaiting = 1'b0;
          return;
        end
        s++;
      end
      finish_op(ST_OK);
    endfunction

    // returns 1 when the request had any effect on the block
    function bit note_request(nfcs_in_t r);
      bit                acted;
      int unsigned       lim;
      logic [ADDR_W-1:0] waddr;
      nfcs_out_t         tail;
      acted = 1'b0;
      batch.delete();
      waddr = {pend_addr, 1'b0};
      case (r.opcode)
        OP_ERASE: begin
          if (mode == MODE_IDLE) begin
            acted = 1'b1;
            if (r.first_sector > r.last_sector) begin
              finish_op(ST_BAD_RANGE);
            end else begin
              range_end = (r.last_sector > LAST_SECTOR) ? SECTORS - 1 : r.last_sector;
              erase_next(r.first_sector);
            end
          end
        end
        OP_PROGRAM: begin
          if (mode == MODE_IDLE) begin
            acted     = 1'b1;
            pend_addr = r.word_address;
            pend_data = r.write_data;
            pend_last = r.last_word;
            queue_result(KIND_READ, {r.word_address, 1'b0}, '0, 1'b1, ST_OK);
            mode     = MODE_PROG_CHECK;
            awaiting = 1'b0;
          end
        end
        OP_READ_DATA: begin
          if (mode != MODE_IDLE && !awaiting) begin
            acted = 1'b1;
            case (mode)
              MODE_ERASE_POLL: begin
                // only the low byte tells an erased sector
                if (r.read_data[7:0] == ERASED_BYTE) erase_next(cur_sector + 1);
                else awaiting = 1'b1;
              end
              MODE_PROG_CHECK: begin
                if ((r.read_data & pend_data) != pend_data) begin
                  finish_op(ST_NOT_ERASED);
                end else begin
                  queue_result(KIND_WRITE, CMD_ADDR_A, CMD_UNLOCK_1, 1'b0, ST_OK);
                  queue_result(KIND_WRITE, CMD_ADDR_B, CMD_UNLOCK_2, 1'b0, ST_OK);
                  queue_result(KIND_WRITE, CMD_ADDR_A, CMD_PROGRAM, 1'b0, ST_OK);
                  queue_result(KIND_WRITE, waddr, pend_data, 1'b1, ST_OK);
                  queue_result(KIND_READ, waddr, '0, 1'b1, ST_OK);
                  mode    = MODE_PROG_POLL;
                  elapsed = 0;
                end
              end
              default: begin
                if (r.read_data == pend_data) begin
                  if (pend_last) finish_op(ST_OK);
                  else mode = MODE_IDLE;  // mid-buffer word: silent
                end else begin
                  awaiting = 1'b1;
                end
              end
            endcase
          end
        end
        OP_TICK: begin
          if (mode != MODE_IDLE && awaiting) begin
            acted = 1'b1;
            lim   = (mode == MODE_ERASE_POLL) ? erase_limit : write_limit;
            if (elapsed < TICK_MAX) elapsed++;
            if (elapsed > lim) begin
              finish_op(ST_TIMEOUT);
            end else begin
              awaiting = 1'b0;
              if (mode == MODE_ERASE_POLL)
                queue_result(KIND_READ, sector_base(cur_sector), '0, 1'b0, ST_OK);
              else
                queue_result(KIND_READ, waddr, '0, 1'b1, ST_OK);
            end
          end
        end
        OP_SET_PROTECT: begin
          if (r.first_sector < SECTORS) begin
            acted = 1'b1;
            protect_map[r.first_sector] = r.protect_flag;
          end
        end
        default: ;
      endcase
      if (batch.size() != 0) begin
        tail = batch.pop_back();
        tail.run_last = 1'b1;
        batch.push_back(tail);
      end
      foreach (batch[i]) expected_q.push_back(batch[i]);
      return acted;
    endfunction

    function void check_result(nfcs_out_t got);
      nfcs_out_t want;
      bit        bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d addr %h data %h word %b status %0d last %b",
                   got.kind, got.bus_address, got.bus_data, got.bus_word,
                   got.status, got.run_last);
        return;
      end
      want = expected_q.pop_front();
      bad  = (got.kind !== want.kind) || (got.bus_address !== want.bus_address) ||
             (got.bus_data !== want.bus_data) || (got.bus_word !== want.bus_word) ||
             (got.status !== want.status) || (got.run_last !== want.run_last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result differs: want kind %0d addr %h data %h word %b status %0d last %b",
                   want.kind, want.bus_address, want.bus_data, want.bus_word,
                   want.status, want.run_last);
          $display("                 got kind %0d addr %h data %h word %b status %0d last %b",
                   got.kind, got.bus_address, got.bus_data, got.bus_word,
                   got.status, got.run_last);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  nfcs_in_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  nfcs_out_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [CFG_W-1:0]  cfg_index = '0;
  logic [TICK_W-1:0] cfg_wdata = '0;

  always #10 clk = ~clk;

  nor_flash_command_sequencer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  flash_seq_scoreboard sb;
  int unsigned         burst_left    = 0;
  int unsigned         acted_count   = 0;
  int unsigned         hold_requests = 0;
  int unsigned         holds_served  = 0;
  int unsigned         hold_left     = 0;
  int unsigned         pattern_left  = 0;
  int unsigned         quiet_cycles  = 0;
  stall_pattern_e      pattern       = STALL_NONE;

  // --------------------------------------------------------------------------
  // Result side: stall pattern of its own, with a long hold when the run asks
  // for one, so the block backs up and stalls its request input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern      = stall_pattern_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(8, 64);
      end
      pattern_left--;
      case (pattern)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // Result check and watchdog: values are sampled as they stood before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("nor_flash_command_sequencer_top: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic nfcs_in_t make_request(logic [2:0] op, logic [7:0] first,
                                            logic [7:0] last, logic [21:0] waddr,
                                            logic [15:0] wdata, logic wlast,
                                            logic [15:0] rdata, logic flag);
    nfcs_in_t r;
    r.opcode       = op;
    r.first_sector = first;
    r.last_sector  = last;
    r.word_address = waddr;
    r.write_data   = wdata;
    r.last_word    = wlast;
    r.read_data    = rdata;
    r.protect_flag = flag;
    return r;
  endfunction

  // Next request as a flash host would send it, given where the model stands.
  // About one in ten is pure noise: any opcode, any fields.
  function automatic nfcs_in_t host_request();
    nfcs_in_t    r;
    int unsigned p;
    r = make_request(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                     22'($urandom), 16'($urandom), 1'($urandom), 16'($urandom),
                     1'($urandom));
    p = $urandom_range(0, 99);
    if (p < 10) return r;
    if (sb.awaiting) begin
      r.opcode = OP_TICK;
      return r;
    end
    case (sb.mode)
      MODE_IDLE: begin
        if (p < 25) begin
          r.opcode = OP_SET_PROTECT;
          if (p < 23) r.first_sector = 8'($urandom_range(0, SECTORS - 1));
          r.protect_flag = ($urandom_range(0, 9) < 3);  // mostly opens sectors
        end else if (p < 60) begin
          r.opcode       = OP_ERASE;
          r.first_sector = (p < 40) ? 8'($urandom_range(0, 15))
                                    : 8'($urandom_range(0, SECTORS - 1));
          case ($urandom_range(0, 9))
            0: begin  // reversed range
              r.last_sector  = r.first_sector;
              r.first_sector = r.first_sector + 8'($urandom_range(1, 120));
            end
            1: begin  // tail of the device, last at or past the end
              r.first_sector = 8'($urandom_range(120, 255));
              r.last_sector  = 8'($urandom_range(SECTORS - 1, 255));
            end
            default: r.last_sector = r.first_sector + 8'($urandom_range(0, 3));
          endcase
        end else begin
          r.opcode    = OP_PROGRAM;
          r.last_word = ($urandom_range(0, 4) != 0);
        end
      end
      MODE_ERASE_POLL: begin
        r.opcode = OP_READ_DATA;
        if (p < 70) r.read_data[7:0] = ERASED_BYTE;
      end
      MODE_PROG_CHECK: begin
        r.opcode = OP_READ_DATA;
        if (p < 85) r.read_data = r.read_data | sb.pend_data;
      end
      default: begin
        r.opcode = OP_READ_DATA;
        if (p < 70) r.read_data = sb.pend_data;
      end
    endcase
    return r;
  endfunction

  // Offer one request in bursts with random gaps; returns at the accepting edge
  task automatic send(input nfcs_in_t req);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    acted_count += sb.note_request(req);
  endtask

  // Stop offering, let every expected result arrive and the block go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [CFG_W-1:0] idx,
                               input logic [TICK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_timeout(idx, value);
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned erase_cfg [4];
    int unsigned write_cfg [4];
    int unsigned target;
    erase_cfg = '{1, 1000000, 3, 2};
    write_cfg = '{1000000, 1, 2, 3};
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset timeouts. Every sector starts protected.
    send(make_request(OP_ERASE, 8'd5, 8'd3, '0, '0, 1'b0, '0, 1'b0));  // bad range
    // whole device while all protected: full scan, then done ok
    send(make_request(OP_ERASE, 8'd0, 8'hFF, '1, '1, 1'b1, '1, 1'b1));
    send(make_request(OP_SET_PROTECT, 8'd0, '0, '0, '0, 1'b0, '0, 1'b0));
    send(make_request(OP_SET_PROTECT, 8'd7, '0, '0, '0, 1'b0, '0, 1'b0));
    send(make_request(OP_SET_PROTECT, 8'd8, '0, '0, '0, 1'b0, '0, 1'b0));
    send(make_request(OP_SET_PROTECT, 8'd134, '0, '0, '0, 1'b0, '0, 1'b0));
    send(make_request(OP_SET_PROTECT, 8'd200, '0, '0, '0, 1'b0, '0, 1'b0)); // out of map
    // empty range once the last sector is clamped
    send(make_request(OP_ERASE, 8'd200, 8'hFF, '0, '0, 1'b0, '0, 1'b0));
    send(make_request(OP_UNUSED, 8'hFF, 8'hFF, '1, '1, 1'b1, '1, 1'b1));
    send(make_request(OP_TICK, '0, '0, '0, '0, 1'b0, '0, 1'b0));            // stray tick
    // small to large sector boundary, with a failed poll and ignored traffic
    send(make_request(OP_ERASE, 8'd7, 8'd8, '0, '0, 1'b0, '0, 1'b0));
    send(make_request(OP_READ_DATA, '0, '0, '0, '0, 1'b0, 16'h12FF, 1'b0));  // high byte ignored
    send(make_request(OP_READ_DATA, '0, '0, '0, '0, 1'b0, 16'h00FE, 1'b0));
    send(make_request(OP_ERASE, 8'd0, 8'd1, '0, '0, 1'b0, '0, 1'b0));       // busy
    send(make_request(OP_READ_DATA, '0, '0, '0, '0, 1'b0, 16'hFFFF, 1'b0));  // waits on tick
    send(make_request(OP_TICK, '0, '0, '0, '0, 1'b0, '0, 1'b0));
    send(make_request(OP_READ_DATA, '0, '0, '0, '0, 1'b0, 16'hFFFF, 1'b0));
    // programme onto a word that is not erased enough
    send(make_request(OP_PROGRAM, '0, '0, '1, 16'hFFFF, 1'b1, '0, 1'b0));
    send(make_request(OP_READ_DATA, '0, '0, '0, '0, 1'b0, 16'h7FFF, 1'b0));
    // mid-buffer word: completes with no done
    send(make_request(OP_PROGRAM, '0, '0, '0, '0, 1'b0, '0, 1'b0));
    send(make_request(OP_READ_DATA, '0, '0, '0, '0, 1'b0, 16'h0000, 1'b0));
    send(make_request(OP_READ_DATA, '0, '0, '0, '0, 1'b0, 16'h0000, 1'b0));
    drain();

    // Zero timeouts: the first tick after a failed poll ends the operation
    write_timeout(CFG_ERASE_TIMEOUT, '0);
    write_timeout(CFG_WRITE_TIMEOUT, '0);
    send(make_request(OP_ERASE, 8'd0, 8'd0, '0, '0, 1'b0, '0, 1'b0));
    send(make_request(OP_READ_DATA, '0, '0, '0, '0, 1'b0, 16'h0000, 1'b0));
    send(make_request(OP_TICK, '0, '0, '0, '0, 1'b0, '0, 1'b0));
    send(make_request(OP_PROGRAM, '0, '0, 22'h2AAAAA, 16'h5A5A, 1'b1, '0, 1'b0));
    send(make_request(OP_READ_DATA, '0, '0, '0, '0, 1'b0, 16'hFFFF, 1'b0));
    send(make_request(OP_READ_DATA, '0, '0, '0, '0, 1'b0, 16'h0000, 1'b0));
    send(make_request(OP_TICK, '0, '0, '0, '0, 1'b0, '0, 1'b0));
    drain();

    // Random host traffic, one timeout setting per phase
    for (int ph = 0; ph < 4; ph++) begin
      write_timeout(CFG_ERASE_TIMEOUT, TICK_W'(erase_cfg[ph]));
      write_timeout(CFG_WRITE_TIMEOUT, TICK_W'(write_cfg[ph]));
      if (ph == 1) hold_requests++;  // back the block up from the first request
      target = acted_count + PHASE_REQUESTS;
      while (acted_count < target) begin
        if (ph == 2 && acted_count == target - PHASE_REQUESTS / 2) begin
          // hold the next request until the block has nothing left to say
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
        send(host_request());
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("nor_flash_command_sequencer_top: match");
    else
      $display("nor_flash_command_sequencer_top: mismatch");
    $finish;
  end

endmodule

### sim.f
rtl/nfcs_pkg.sv
rtl/nfcs_ctrl.sv
rtl/nfcs_dp.sv
rtl/nor_flash_command_sequencer_top.sv
tb/tb.sv
